@@ hdl/fqrs_pkg.sv @@
// Shared widths, configuration record, register indexes and width helpers for the root selector.
`default_nettype none

package fqrs_pkg;

   localparam int COORD_W      = 32;
   localparam int DIR_W        = 18;
   localparam int DIST_W       = 32;
   localparam int AXIS_W       = 18;
   localparam int HEIGHT_W     = 31;
   localparam int EPS_W        = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int AXIAL_STAGES = 4;
   localparam int NUM_STAGES   = AXIAL_STAGES + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_AXIS_X   = 3'd3,
      CSR_AXIS_Y   = 3'd4,
      CSR_AXIS_Z   = 3'd5,
      CSR_HEIGHT   = 3'd6,
      CSR_EPSILON  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic signed [AXIS_W-1:0]  axis_x;
      logic signed [AXIS_W-1:0]  axis_y;
      logic signed [AXIS_W-1:0]  axis_z;
      logic [HEIGHT_W-1:0]       height;
      logic [EPS_W-1:0]          epsilon;
   } cfg_type;

   // width of the point offset origin - center + dir * t
   function automatic int r_width(input int frac);
      int m_w;
      begin
         m_w = DIR_W + DIST_W - frac;
         return ((m_w > COORD_W + 1) ? m_w : COORD_W + 1) + 1;
      end
   endfunction

   // width of twice the axial offset
   function automatic int y2_width(input int frac);
      return AXIS_W + r_width(frac) + 2 - frac + 1;
   endfunction

endpackage

`default_nettype wire

@@ hdl/fqrs_if.sv @@
// Ray request, hit response and register write channels.
`default_nettype none

interface fqrs_req_if;
   import fqrs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      func;
   logic signed [COORD_W-1:0] origin_x;
   logic signed [COORD_W-1:0] origin_y;
   logic signed [COORD_W-1:0] origin_z;
   logic signed [DIR_W-1:0]   dir_x;
   logic signed [DIR_W-1:0]   dir_y;
   logic signed [DIR_W-1:0]   dir_z;
   logic signed [DIST_W-1:0]  root_one;
   logic signed [DIST_W-1:0]  root_two;

   modport source (output valid, func, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   root_one, root_two, input ready);
   modport sink   (input valid, func, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   root_one, root_two, output ready);
endinterface

interface fqrs_rsp_if;
   import fqrs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic signed [DIST_W-1:0] hit_distance;

   modport source (output valid, hit, hit_distance, input ready);
   modport sink   (input valid, hit, hit_distance, output ready);
endinterface

interface fqrs_csr_if;
   import fqrs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/fqrs_csr.sv @@
// Object configuration registers: center, axis, height and epsilon.
`default_nettype none

module fqrs_csr #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   fqrs_csr_if.sink         csr_ch,
   output fqrs_pkg::cfg_type cfg
);
   import fqrs_pkg::*;

   localparam logic [AXIS_W-1:0] AxisOne = AXIS_W'(64'd1 << FRAC_BITS);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   cfg_type cfg_rst;

   always_comb begin
      cfg_rst          = '0;
      cfg_rst.axis_z   = AxisOne;
      cfg_rst.epsilon  = EPS_W'(1);

      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_CENTER_X: cfg_in.center_x = csr_ch.data;
            CSR_CENTER_Y: cfg_in.center_y = csr_ch.data;
            CSR_CENTER_Z: cfg_in.center_z = csr_ch.data;
            CSR_AXIS_X:   cfg_in.axis_x   = csr_ch.data[AXIS_W-1:0];
            CSR_AXIS_Y:   cfg_in.axis_y   = csr_ch.data[AXIS_W-1:0];
            CSR_AXIS_Z:   cfg_in.axis_z   = csr_ch.data[AXIS_W-1:0];
            CSR_HEIGHT:   cfg_in.height   = csr_ch.data[HEIGHT_W-1:0];
            CSR_EPSILON:  cfg_in.epsilon  = csr_ch.data[EPS_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_rst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ch.ready = !reset;
   assign cfg          = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/fqrs_axial.sv @@
// Four-stage pipeline that computes twice the axial offset of the point at one root.
`default_nettype none

module fqrs_axial #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                            clock,
   input  logic [fqrs_pkg::AXIAL_STAGES-1:0]               en,
   input  fqrs_pkg::cfg_type                               cfg,
   input  logic signed [fqrs_pkg::COORD_W-1:0]             origin [3],
   input  logic signed [fqrs_pkg::DIR_W-1:0]               dir [3],
   input  logic signed [fqrs_pkg::DIST_W-1:0]              t,
   output logic signed [fqrs_pkg::DIST_W-1:0]              t_out,
   output logic signed [fqrs_pkg::y2_width(FRAC_BITS)-1:0] y2
);
   import fqrs_pkg::*;

   localparam int P_W  = DIR_W + DIST_W;
   localparam int D_W  = COORD_W + 1;
   localparam int R_W  = r_width(FRAC_BITS);
   localparam int A_W  = AXIS_W + R_W;
   localparam int S_W  = A_W + 2;
   localparam int Y2_W = y2_width(FRAC_BITS);

   logic signed [COORD_W-1:0] center [3];
   logic signed [AXIS_W-1:0]  axis [3];

   logic signed [P_W-1:0]    prod_ff [3];
   logic signed [P_W-1:0]    prod_in [3];
   logic signed [D_W-1:0]    diff_ff [3];
   logic signed [D_W-1:0]    diff_in [3];
   logic signed [R_W-1:0]    r_ff [3];
   logic signed [R_W-1:0]    r_in [3];
   logic signed [A_W-1:0]    ap_ff [3];
   logic signed [A_W-1:0]    ap_in [3];
   logic signed [S_W-1:0]    sum;
   logic signed [S_W-1:0]    shifted;
   logic signed [Y2_W-1:0]   y2_ff;
   logic signed [Y2_W-1:0]   y2_in;
   logic signed [DIST_W-1:0] t0_ff;
   logic signed [DIST_W-1:0] t1_ff;
   logic signed [DIST_W-1:0] t2_ff;
   logic signed [DIST_W-1:0] t3_ff;

   assign center[0] = cfg.center_x;
   assign center[1] = cfg.center_y;
   assign center[2] = cfg.center_z;
   assign axis[0]   = cfg.axis_x;
   assign axis[1]   = cfg.axis_y;
   assign axis[2]   = cfg.axis_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = P_W'(dir[i]) * P_W'(t);
         diff_in[i] = D_W'(origin[i]) - D_W'(center[i]);
         r_in[i]    = R_W'(diff_ff[i]) + R_W'(prod_ff[i] >>> FRAC_BITS);
         ap_in[i]   = A_W'(axis[i]) * A_W'(r_ff[i]);
      end
      sum     = S_W'(ap_ff[0]) + S_W'(ap_ff[1]) + S_W'(ap_ff[2]);
      shifted = sum >>> FRAC_BITS;
      y2_in   = {shifted[S_W-FRAC_BITS-1:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         diff_ff <= diff_in;
         t0_ff   <= t;
      end
      if (en[1]) begin
         r_ff  <= r_in;
         t1_ff <= t0_ff;
      end
      if (en[2]) begin
         ap_ff <= ap_in;
         t2_ff <= t1_ff;
      end
      if (en[3]) begin
         y2_ff <= y2_in;
         t3_ff <= t2_ff;
      end
   end

   assign y2    = y2_ff;
   assign t_out = t3_ff;

endmodule

`default_nettype wire

@@ hdl/fqrs_select.sv @@
// Final stage: bound tests on both roots, nearest-root choice and the result register.
`default_nettype none

module fqrs_select #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                            clock,
   input  logic                                            en,
   input  fqrs_pkg::cfg_type                               cfg,
   input  logic                                            func,
   input  logic signed [fqrs_pkg::DIST_W-1:0]              t_a,
   input  logic signed [fqrs_pkg::DIST_W-1:0]              t_b,
   input  logic signed [fqrs_pkg::y2_width(FRAC_BITS)-1:0] y2_a,
   input  logic signed [fqrs_pkg::y2_width(FRAC_BITS)-1:0] y2_b,
   output logic                                            hit,
   output logic signed [fqrs_pkg::DIST_W-1:0]              hit_distance
);
   import fqrs_pkg::*;

   localparam int Y2_W  = y2_width(FRAC_BITS);
   localparam int CMP_W = ((Y2_W > HEIGHT_W + 2) ? Y2_W : HEIGHT_W + 2) + 1;
   localparam logic [DIST_W-1:0] MissDist = DIST_W'(-(longint'(1) << FRAC_BITS));

   logic signed [CMP_W-1:0]  eps_c;
   logic signed [CMP_W-1:0]  hpos_c;
   logic signed [CMP_W-1:0]  hneg_c;
   logic signed [CMP_W-1:0]  lim_c;
   logic signed [CMP_W-1:0]  ya_c;
   logic signed [CMP_W-1:0]  yb_c;
   logic                     ok_a;
   logic                     ok_b;
   logic                     hit_in;
   logic signed [DIST_W-1:0] dist_in;
   logic                     hit_ff;
   logic signed [DIST_W-1:0] dist_ff;

   always_comb begin
      eps_c  = CMP_W'(cfg.epsilon);
      hpos_c = CMP_W'(cfg.height);
      hneg_c = -hpos_c;
      lim_c  = hpos_c + (eps_c <<< 1);
      ya_c   = CMP_W'(y2_a);
      yb_c   = CMP_W'(y2_b);

      if (func) begin
         ok_a = (ya_c < lim_c) && (ya_c > hneg_c);
         ok_b = (yb_c < lim_c) && (yb_c > hneg_c);
      end else begin
         ok_a = (ya_c <= hpos_c) && (ya_c >= hneg_c);
         ok_b = (yb_c <= hpos_c) && (yb_c >= hneg_c);
      end
      ok_a = ok_a && (CMP_W'(t_a) > eps_c);
      ok_b = ok_b && (CMP_W'(t_b) > eps_c);

      hit_in = ok_a || ok_b;
      priority if (ok_a && ok_b) begin
         dist_in = (t_a < t_b) ? t_a : t_b;
      end else if (ok_a) begin
         dist_in = t_a;
      end else if (ok_b) begin
         dist_in = t_b;
      end else begin
         dist_in = MissDist;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
      end
   end

   assign hit          = hit_ff;
   assign hit_distance = dist_ff;

endmodule

`default_nettype wire

@@ hdl/finite_quadric_root_select.sv @@
// Top level of the finite cylinder / cone root selector.
//
//   channel  direction  word                                       handshake
//   req_ch   in         func, origin xyz, dir xyz, two roots       valid/ready
//   rsp_ch   out        hit, hit_distance                          valid/ready
//   csr_ch   in         register index, write data                 valid/ready
//
// One word per cycle while rsp_ch does not stall; five register stages from acceptance to rsp_ch.valid.
// Stages: products dir*t, point offset, axis products, axial sum, bound test.
// Each stage advances when empty or when the stage after it advances.
// A stalled rsp_ch backs up stage by stage; no word is dropped or repeated.
// Reset clears all stage valid bits, loads register defaults and holds both ready low.
`default_nettype none

module finite_quadric_root_select #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   fqrs_req_if.sink   req_ch,
   fqrs_rsp_if.source rsp_ch,
   fqrs_csr_if.sink   csr_ch
);
   import fqrs_pkg::*;

   localparam int Y2_W = y2_width(FRAC_BITS);
   localparam int LAST = NUM_STAGES - 1;
   localparam logic [DIST_W-1:0] MissDist = DIST_W'(-(longint'(1) << FRAC_BITS));

   cfg_type                   cfg;
   logic [NUM_STAGES-1:0]     v_ff;
   logic [NUM_STAGES-1:0]     v_in;
   logic [NUM_STAGES-1:0]     en;
   logic [AXIAL_STAGES-1:0]   func_ff;
   logic signed [COORD_W-1:0] origin [3];
   logic signed [DIR_W-1:0]   dir [3];
   logic signed [DIST_W-1:0]  t_a;
   logic signed [DIST_W-1:0]  t_b;
   logic signed [Y2_W-1:0]    y2_a;
   logic signed [Y2_W-1:0]    y2_b;

   fqrs_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   assign origin[0] = req_ch.origin_x;
   assign origin[1] = req_ch.origin_y;
   assign origin[2] = req_ch.origin_z;
   assign dir[0]    = req_ch.dir_x;
   assign dir[1]    = req_ch.dir_y;
   assign dir[2]    = req_ch.dir_z;

   always_comb begin
      en[LAST] = !v_ff[LAST] || rsp_ch.ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_ch.valid : v_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         func_ff[0] <= req_ch.func;
      end
      for (int k = 1; k < AXIAL_STAGES; k++) begin
         if (en[k]) begin
            func_ff[k] <= func_ff[k-1];
         end
      end
   end

   fqrs_axial #(.FRAC_BITS(FRAC_BITS)) u_axial_a (
      .clock  (clock),
      .en     (en[AXIAL_STAGES-1:0]),
      .cfg    (cfg),
      .origin (origin),
      .dir    (dir),
      .t      (req_ch.root_one),
      .t_out  (t_a),
      .y2     (y2_a)
   );

   fqrs_axial #(.FRAC_BITS(FRAC_BITS)) u_axial_b (
      .clock  (clock),
      .en     (en[AXIAL_STAGES-1:0]),
      .cfg    (cfg),
      .origin (origin),
      .dir    (dir),
      .t      (req_ch.root_two),
      .t_out  (t_b),
      .y2     (y2_b)
   );

   fqrs_select #(.FRAC_BITS(FRAC_BITS)) u_select (
      .clock        (clock),
      .en           (en[LAST]),
      .cfg          (cfg),
      .func         (func_ff[AXIAL_STAGES-1]),
      .t_a          (t_a),
      .t_b          (t_b),
      .y2_a         (y2_a),
      .y2_b         (y2_b),
      .hit          (rsp_ch.hit),
      .hit_distance (rsp_ch.hit_distance)
   );

   assign req_ch.ready = en[0] && !reset;
   assign rsp_ch.valid = v_ff[LAST];

   a_reset_clears : assert property (@(posedge clock)
      reset |=> v_ff == '0)
      else $error("stage valid bits not cleared by reset");

   a_miss_value : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.hit |-> rsp_ch.hit_distance == MissDist)
      else $error("miss word without minus one distance");

   a_hit_beyond_eps : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.hit |->
         $signed(rsp_ch.hit_distance) > $signed({1'b0, cfg.epsilon}))
      else $error("hit distance not beyond epsilon");

   a_full_blocks_req : assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while pipeline full and stalled");

   a_stall_holds_last : assert property (@(posedge clock) disable iff (reset)
      v_ff[LAST] && !rsp_ch.ready |=> v_ff[LAST] && $stable(rsp_ch.hit_distance))
      else $error("stalled result word lost or changed");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the finite cylinder / cone root selector.

module tb_top;
   import fqrs_pkg::*;

   localparam int  FRAC        = 16;
   localparam int  PHASES      = 10;
   localparam int  PHASE_WORDS = 175;
   localparam int  CYCLE_LIMIT = 200000;

   typedef enum logic {KIND_CYLINDER = 1'b0, KIND_CONE = 1'b1} object_kind_type;
   typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_type;
   typedef enum int {
      PLAN_Z_AXIS, PLAN_XY_AXIS, PLAN_SKEW, PLAN_LOW_EXTREME, PLAN_HIGH_EXTREME
   } shape_plan_type;

   typedef struct packed {
      object_kind_type           kind;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic signed [DIR_W-1:0]   dir_z;
      logic signed [DIST_W-1:0]  root_one;
      logic signed [DIST_W-1:0]  root_two;
   } ray_word_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DIST_W-1:0] hit_distance;
   } hit_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fqrs_req_if req_if ();
   fqrs_rsp_if rsp_if ();
   fqrs_csr_if csr_if ();

   finite_quadric_root_select #(.FRAC_BITS(FRAC)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   cfg_type      obj_cfg;
   ray_word_type ray_queue [$];
   hit_word_type hit_expect [$];
   bit           ray_taken = 1'b0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit root_inside(ray_word_type w, longint t);
      longint org [3];
      longint dir [3];
      longint ctr [3];
      longint ax [3];
      longint eps;
      longint height;
      longint acc;
      longint y2;
      org[0] = w.origin_x;  org[1] = w.origin_y;  org[2] = w.origin_z;
      dir[0] = w.dir_x;     dir[1] = w.dir_y;     dir[2] = w.dir_z;
      ctr[0] = obj_cfg.center_x;  ctr[1] = obj_cfg.center_y;  ctr[2] = obj_cfg.center_z;
      ax[0] = obj_cfg.axis_x;     ax[1] = obj_cfg.axis_y;     ax[2] = obj_cfg.axis_z;
      eps = obj_cfg.epsilon;
      height = obj_cfg.height;
      if (t <= eps) return 1'b0;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         acc += ax[i] * (org[i] - ctr[i] + ((dir[i] * t) >>> FRAC));
      end
      y2 = 2 * (acc >>> FRAC);
      if (w.kind == KIND_CYLINDER) return ((y2 < 0) ? -y2 : y2) <= height;
      return (y2 - height < 2 * eps) && (y2 - height > -2 * height);
   endfunction

   function automatic hit_word_type predict_hit(ray_word_type w);
      hit_word_type h;
      longint       t1;
      longint       t2;
      longint       pick;
      bit           ok1;
      bit           ok2;
      t1 = w.root_one;
      t2 = w.root_two;
      ok1 = root_inside(w, t1);
      ok2 = root_inside(w, t2);
      if (ok1 && ok2) begin
         pick = (t1 < t2) ? t1 : t2;
      end else if (ok1) begin
         pick = t1;
      end else if (ok2) begin
         pick = t2;
      end else begin
         pick = -(longint'(1) << FRAC);
      end
      h.hit = ok1 || ok2;
      h.hit_distance = DIST_W'(pick);
      return h;
   endfunction

   function automatic cfg_type pick_object(shape_plan_type plan);
      cfg_type c;
      c = '0;
      c.center_x = int'($urandom_range(1 << 25)) - (1 << 24);
      c.center_y = int'($urandom_range(1 << 25)) - (1 << 24);
      c.center_z = int'($urandom_range(1 << 25)) - (1 << 24);
      case (plan)
         PLAN_Z_AXIS: begin
            c.axis_z = $urandom_range(1) ? 65536 : -65536;
            c.height = $urandom_range(8 << 16, 1 << 16);
            c.epsilon = $urandom_range(4096);
         end
         PLAN_XY_AXIS: begin
            if ($urandom_range(1)) c.axis_x = $urandom_range(1) ? 65536 : -65536;
            else c.axis_y = $urandom_range(1) ? 65536 : -65536;
            c.height = $urandom_range(1 << 22, 1);
            c.epsilon = $urandom_range(65535);
         end
         PLAN_SKEW: begin
            c.center_x = $urandom();
            c.center_y = $urandom();
            c.center_z = $urandom();
            c.axis_x = int'($urandom_range(131072)) - 65536;
            c.axis_y = int'($urandom_range(131072)) - 65536;
            c.axis_z = int'($urandom_range(131072)) - 65536;
            c.height = $urandom_range(1 << 24);
            c.epsilon = $urandom_range(65535);
         end
         PLAN_LOW_EXTREME: begin
            c.center_x = 32'sh8000_0000;
            c.center_y = 32'sh8000_0000;
            c.center_z = 32'sh8000_0000;
            c.axis_x = 18'sh20000;
            c.axis_y = 18'sh20000;
            c.axis_z = 18'sh20000;
            c.height = '0;
            c.epsilon = '0;
         end
         default: begin
            c.center_x = 32'sh7fff_ffff;
            c.center_y = 32'sh7fff_ffff;
            c.center_z = 32'sh7fff_ffff;
            c.axis_x = 18'sh1ffff;
            c.axis_y = 18'sh1ffff;
            c.axis_z = 18'sh1ffff;
            c.height = '1;
            c.epsilon = '1;
         end
      endcase
      return c;
   endfunction

   function automatic ray_word_type make_ray();
      ray_word_type w;
      int           pick;
      longint       t;
      longint       other;
      longint       p_range;
      longint       d [3];
      longint       p [3];
      longint       c [3];
      pick = $urandom_range(99);
      w.kind = object_kind_type'($urandom_range(1));
      if (pick >= 80) begin
         w.origin_x = $urandom();
         w.origin_y = $urandom();
         w.origin_z = $urandom();
         w.dir_x = DIR_W'($urandom());
         w.dir_y = DIR_W'($urandom());
         w.dir_z = DIR_W'($urandom());
         w.root_one = $urandom();
         w.root_two = $urandom();
         return w;
      end
      c[0] = obj_cfg.center_x;  c[1] = obj_cfg.center_y;  c[2] = obj_cfg.center_z;
      p_range = ((obj_cfg.height > (1 << 22)) ? (1 << 22) : obj_cfg.height) + 65536;
      t = $urandom_range(1 << 20);
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'($urandom_range(131072)) - 65536;
         p[i] = longint'($urandom_range(2 * p_range)) - p_range;
      end
      w.origin_x = COORD_W'(c[0] + p[0] - ((d[0] * t) >>> FRAC));
      w.origin_y = COORD_W'(c[1] + p[1] - ((d[1] * t) >>> FRAC));
      w.origin_z = COORD_W'(c[2] + p[2] - ((d[2] * t) >>> FRAC));
      w.dir_x = DIR_W'(d[0]);
      w.dir_y = DIR_W'(d[1]);
      w.dir_z = DIR_W'(d[2]);
      other = t + longint'($urandom_range(1 << 19)) - (1 << 18);
      if (pick < 10) other = longint'(obj_cfg.epsilon) + $urandom_range(2) - 1;
      if ($urandom_range(1)) begin
         w.root_one = DIST_W'(t);
         w.root_two = DIST_W'(other);
      end else begin
         w.root_one = DIST_W'(other);
         w.root_two = DIST_W'(t);
      end
      return w;
   endfunction

   task automatic queue_ray(object_kind_type kind, int ox, int oy, int oz,
                            int dx, int dy, int dz, int r1, int r2);
      ray_word_type w;
      w.kind = kind;
      w.origin_x = ox;  w.origin_y = oy;  w.origin_z = oz;
      w.dir_x = DIR_W'(dx);  w.dir_y = DIR_W'(dy);  w.dir_z = DIR_W'(dz);
      w.root_one = r1;
      w.root_two = r2;
      ray_queue.push_back(w);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] word;
      case (idx)
         CSR_AXIS_X, CSR_AXIS_Y, CSR_AXIS_Z: mask = (1 << AXIS_W) - 1;
         CSR_HEIGHT:                         mask = (1 << HEIGHT_W) - 1;
         CSR_EPSILON:                        mask = (1 << EPS_W) - 1;
         default:                            mask = '1;
      endcase
      word = ($urandom() & ~mask) | (value & mask);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= word;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      case (idx)
         CSR_CENTER_X: obj_cfg.center_x = word;
         CSR_CENTER_Y: obj_cfg.center_y = word;
         CSR_CENTER_Z: obj_cfg.center_z = word;
         CSR_AXIS_X:   obj_cfg.axis_x = word[AXIS_W-1:0];
         CSR_AXIS_Y:   obj_cfg.axis_y = word[AXIS_W-1:0];
         CSR_AXIS_Z:   obj_cfg.axis_z = word[AXIS_W-1:0];
         CSR_HEIGHT:   obj_cfg.height = word[HEIGHT_W-1:0];
         CSR_EPSILON:  obj_cfg.epsilon = word[EPS_W-1:0];
      endcase
   endtask

   task automatic program_object(cfg_type c);
      write_reg(CSR_CENTER_X, c.center_x);
      write_reg(CSR_CENTER_Y, c.center_y);
      write_reg(CSR_CENTER_Z, c.center_z);
      write_reg(CSR_AXIS_X, CSR_DATA_W'(c.axis_x));
      write_reg(CSR_AXIS_Y, CSR_DATA_W'(c.axis_y));
      write_reg(CSR_AXIS_Z, CSR_DATA_W'(c.axis_z));
      write_reg(CSR_HEIGHT, CSR_DATA_W'(c.height));
      write_reg(CSR_EPSILON, CSR_DATA_W'(c.epsilon));
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_pace(pace_type pace);
      case (pace)
         PACE_FULL:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         PACE_SEND_IDLE:  begin send_idle_pct = 88; recv_stall_pct = 0;  end
         PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 88; end
         default:         begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
   endtask

   task automatic wait_drained();
      while (ray_queue.size() != 0 || req_if.valid || hit_expect.size() != 0)
         @(posedge clock);
   endtask

   always @(negedge clock) begin : drive_rays
      ray_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || ray_taken) begin
         if (ray_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = ray_queue.pop_front();
            req_if.func <= w.kind;
            req_if.origin_x <= w.origin_x;
            req_if.origin_y <= w.origin_y;
            req_if.origin_z <= w.origin_z;
            req_if.dir_x <= w.dir_x;
            req_if.dir_y <= w.dir_y;
            req_if.dir_z <= w.dir_z;
            req_if.root_one <= w.root_one;
            req_if.root_two <= w.root_two;
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_hits
      ray_word_type w;
      hit_word_type want;
      ray_taken = !reset && req_if.valid && req_if.ready;
      if (ray_taken) begin
         w.kind = object_kind_type'(req_if.func);
         w.origin_x = req_if.origin_x;
         w.origin_y = req_if.origin_y;
         w.origin_z = req_if.origin_z;
         w.dir_x = req_if.dir_x;
         w.dir_y = req_if.dir_y;
         w.dir_z = req_if.dir_z;
         w.root_one = req_if.root_one;
         w.root_two = req_if.root_two;
         hit_expect.push_back(predict_hit(w));
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (hit_expect.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word hit=%0b hit_distance=%0d", $time,
                     rsp_if.hit, rsp_if.hit_distance);
         end else begin
            want = hit_expect.pop_front();
            if (rsp_if.hit !== want.hit) begin
               mismatch_count++;
               $display("%0t: hit expected %0b got %0b", $time, want.hit, rsp_if.hit);
            end
            if (rsp_if.hit_distance !== want.hit_distance) begin
               mismatch_count++;
               $display("%0t: hit_distance expected %0d got %0d", $time,
                        want.hit_distance, rsp_if.hit_distance);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin : stimulus
      cfg_type c;
      req_if.valid = 1'b0;
      req_if.func = 1'b0;
      req_if.origin_x = '0;
      req_if.origin_y = '0;
      req_if.origin_z = '0;
      req_if.dir_x = '0;
      req_if.dir_y = '0;
      req_if.dir_z = '0;
      req_if.root_one = '0;
      req_if.root_two = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_CENTER_X;
      csr_if.data = '0;
      obj_cfg = '0;
      obj_cfg.axis_z = 65536;
      obj_cfg.epsilon = 1;
      set_pace(PACE_FULL);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: unit z axis, zero height, one-LSB margin
      queue_ray(KIND_CYLINDER, 0, 0, -(5 << 16), 0, 0, 65536, 5 << 16, 3 << 16);
      queue_ray(KIND_CONE, 0, 0, 0, 0, 0, 65536, 1, 2);
      wait_drained();

      c = '0;
      c.axis_z = 65536;
      c.height = 4 << 16;
      c.epsilon = 16;
      program_object(c);
      queue_ray(KIND_CYLINDER, 0, 0, 0, 0, 0, 65536, 65536, 98304);
      queue_ray(KIND_CYLINDER, 0, 0, 0, 0, 0, 65536, 98304, 65536);
      queue_ray(KIND_CYLINDER, 0, 0, 0, 0, 0, 65536, 65536, 65536);
      queue_ray(KIND_CYLINDER, 0, 0, 0, 0, 0, 65536, 16, 17);
      queue_ray(KIND_CYLINDER, 0, 0, 0, 0, 0, 65536, -65536, 131072);
      queue_ray(KIND_CYLINDER, 0, 0, 0, 0, 0, 65536, 131073, -5);
      queue_ray(KIND_CYLINDER, 0, 0, 0, 0, 0, 65536, 131073, 131072);
      queue_ray(KIND_CONE, 0, 0, 0, 0, 0, 65536, 131072 + 15, 131072 + 16);
      queue_ray(KIND_CONE, 0, 0, 0, 0, 0, 65536, 131072 + 16, 131072 + 15);
      queue_ray(KIND_CONE, 0, 0, -(3 << 16), 0, 0, 65536, 65536, 65537);
      queue_ray(KIND_CYLINDER, 0, 0, -(3 << 16), 0, 0, 65536, 65536, 65535);
      queue_ray(KIND_CONE, 0, 0, 0, 0, 0, 65536, 0, -1);
      queue_ray(KIND_CONE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                131071, 131071, 131071, 32'h7fff_ffff, 32'h7fff_ffff);
      queue_ray(KIND_CYLINDER, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                -131072, -131072, -131072, 32'h8000_0000, 32'h8000_0000);
      queue_ray(KIND_CYLINDER, 0, 0, 0, 65536, -65536, 65536, 1 << 16, 2 << 16);
      queue_ray(KIND_CONE, 0, 0, 0, -65536, 65536, -65536, 32'h7fff_ffff, 32'h8000_0000);
      queue_ray(KIND_CYLINDER, 1 << 16, -(1 << 16), 0, 0, 65536, 0, 17, 1 << 16);
      queue_ray(KIND_CONE, 0, 0, 3 << 16, 0, 0, -65536, 1 << 16, 6 << 16);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         set_pace(pace_type'(p % 4));
         program_object(pick_object(shape_plan_type'(p % 5)));
         repeat (PHASE_WORDS) ray_queue.push_back(make_ray());
         wait_drained();
      end

      repeat (4 * NUM_STAGES) @(posedge clock);
      if (hit_expect.size() != 0) begin
         mismatch_count++;
         $display("%0t: words expected %0d more, got 0", $time, hit_expect.size());
      end
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/fqrs_pkg.sv
hdl/fqrs_if.sv
hdl/fqrs_csr.sv
hdl/fqrs_axial.sv
hdl/fqrs_select.sv
hdl/finite_quadric_root_select.sv
bench/tb_top.sv
